// ===== design/dcso_pkg.sv =====
// Shared types and constants for the direction to screen offset pipeline.
// No dependencies.
package dcso_pkg;

  localparam int IN_W       = 16;
  localparam int OUT_W      = 17;
  localparam int FOCAL_W    = 13;
  localparam int RADIUS_W   = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd1;

  // 0.05 in Q1.14, rounded up
  localparam logic signed [IN_W-1:0] FRONT_MIN = 16'sd820;

  localparam int NUM_W  = 64;
  localparam int DEN_W  = 32;
  localparam int QUO_W  = 34;
  localparam int ROOT_W = 17;
  localparam int SREM_W = 20;

  localparam int FRONT_STAGES = 4;
  localparam int LATENCY      = FRONT_STAGES + QUO_W + ROOT_W + 1;

  typedef struct packed {
    logic ok;
    logic neg;
    logic pin;
  } lane_tag_t;

endpackage

// ===== design/dcso_front.sv =====
// Front stages: magnitudes, squares, clamp test and divider operand setup.
// Depends on dcso_pkg.
module dcso_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_v,
  input  logic signed [15:0]             fwd,
  input  logic signed [15:0]             rgt,
  input  logic signed [15:0]             upc,
  input  logic [12:0]                    focal,
  input  logic [11:0]                    radius,
  output logic                           out_v,
  output logic [dcso_pkg::NUM_W-1:0]     num_x,
  output logic [dcso_pkg::NUM_W-1:0]     num_y,
  output logic [dcso_pkg::DEN_W-1:0]     den,
  output dcso_pkg::lane_tag_t            tag_x,
  output dcso_pkg::lane_tag_t            tag_y
);
  import dcso_pkg::*;

  // stage A
  logic        a_v_r, a_negx_r, a_negy_r, a_front_r, a_side_r, a_cfg_r;
  logic [30:0] a_ar2_r, a_au2_r;
  logic [28:0] a_px_r, a_py_r;
  logic [14:0] a_f_r;
  logic [29:0] a_f2_r;
  logic [23:0] a_r2_r;
  logic [25:0] a_fl2_r;
  logic [15:0] ar, au;

  assign ar = rgt[15] ? 16'(-rgt) : 16'(rgt);
  assign au = upc[15] ? 16'(-upc) : 16'(upc);

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else        a_v_r <= in_v;
    a_negx_r  <= rgt[15];
    a_negy_r  <= !upc[15] && (upc != 16'sd0);
    a_front_r <= fwd >= FRONT_MIN;
    a_side_r  <= (ar > 16'd1) || (au > 16'd1);
    a_cfg_r   <= (focal != 13'd0) && (radius != 12'd0);
    a_ar2_r   <= 31'(ar * ar);
    a_au2_r   <= 31'(au * au);
    a_px_r    <= 29'(ar * focal);
    a_py_r    <= 29'(au * focal);
    a_f_r     <= fwd[14:0];
    a_f2_r    <= 30'(fwd[14:0] * fwd[14:0]);
    a_r2_r    <= 24'(radius * radius);
    a_fl2_r   <= 26'(focal * focal);
  end

  // stage B
  logic        b_v_r, b_negx_r, b_negy_r, b_front_r, b_side_r, b_cfg_r;
  logic [31:0] b_s_r;
  logic [53:0] b_rhsx_r, b_rhsy_r, b_lim_r;
  logic [28:0] b_px_r, b_py_r;
  logic [14:0] b_f_r;
  logic [25:0] b_fl2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else        b_v_r <= a_v_r;
    b_negx_r  <= a_negx_r;
    b_negy_r  <= a_negy_r;
    b_front_r <= a_front_r;
    b_side_r  <= a_side_r;
    b_cfg_r   <= a_cfg_r;
    b_s_r     <= 32'(a_ar2_r) + 32'(a_au2_r);
    b_rhsx_r  <= 54'(a_r2_r * a_ar2_r);
    b_rhsy_r  <= 54'(a_r2_r * a_au2_r);
    b_lim_r   <= 54'(a_r2_r * a_f2_r);
    b_px_r    <= a_px_r;
    b_py_r    <= a_py_r;
    b_f_r     <= a_f_r;
    b_fl2_r   <= a_fl2_r;
  end

  // stage C
  logic        c_v_r, c_negx_r, c_negy_r, c_front_r, c_side_r, c_cfg_r;
  logic [31:0] c_s_r;
  logic [53:0] c_rhsx_r, c_rhsy_r, c_lim_r;
  logic [57:0] c_lhs_r;
  logic [28:0] c_px_r, c_py_r;
  logic [14:0] c_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else        c_v_r <= b_v_r;
    c_negx_r  <= b_negx_r;
    c_negy_r  <= b_negy_r;
    c_front_r <= b_front_r;
    c_side_r  <= b_side_r;
    c_cfg_r   <= b_cfg_r;
    c_s_r     <= b_s_r;
    c_rhsx_r  <= b_rhsx_r;
    c_rhsy_r  <= b_rhsy_r;
    c_lim_r   <= b_lim_r;
    c_lhs_r   <= 58'(b_s_r * b_fl2_r);
    c_px_r    <= b_px_r;
    c_py_r    <= b_py_r;
    c_f_r     <= b_f_r;
  end

  // stage D: pick projection divide or pinned divide
  logic pin, ok;
  assign pin = !c_front_r || (c_lhs_r > 58'(c_lim_r));
  assign ok  = c_cfg_r && (c_front_r || c_side_r);

  always_ff @(posedge clk) begin
    if (!rst_n) out_v <= 1'b0;
    else        out_v <= c_v_r;
    num_x <= pin ? {c_rhsx_r, 10'b0} : NUM_W'({c_px_r, 5'b0}) + NUM_W'(c_f_r);
    num_y <= pin ? {c_rhsy_r, 10'b0} : NUM_W'({c_py_r, 5'b0}) + NUM_W'(c_f_r);
    den   <= pin ? c_s_r : DEN_W'({c_f_r, 1'b0});
    tag_x <= '{ok: ok, neg: c_negx_r, pin: pin};
    tag_y <= '{ok: ok, neg: c_negy_r, pin: pin};
  end

endmodule

// ===== design/dcso_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on dcso_pkg.
module dcso_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_v,
  input  logic [dcso_pkg::NUM_W-1:0] num,
  input  logic [dcso_pkg::DEN_W-1:0] den,
  input  dcso_pkg::lane_tag_t        in_tag,
  output logic                       out_v,
  output logic [dcso_pkg::QUO_W-1:0] quo,
  output dcso_pkg::lane_tag_t        out_tag
);
  import dcso_pkg::*;

  logic             v_r   [QUO_W];
  logic [DEN_W-1:0] rem_r [QUO_W];
  logic [QUO_W-1:0] nlo_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] q_r   [QUO_W];
  lane_tag_t        tag_r [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic             v_in;
    logic [DEN_W-1:0] rem_in, den_in, rem_nxt;
    logic [QUO_W-1:0] nlo_in, q_in, q_nxt;
    lane_tag_t        tag_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (i == 0) begin : g_first
      assign v_in   = in_v;
      assign rem_in = DEN_W'(num[NUM_W-1:QUO_W]);
      assign nlo_in = num[QUO_W-1:0];
      assign den_in = den;
      assign q_in   = '0;
      assign tag_in = in_tag;
    end else begin : g_next
      assign v_in   = v_r[i-1];
      assign rem_in = rem_r[i-1];
      assign nlo_in = nlo_r[i-1];
      assign den_in = den_r[i-1];
      assign q_in   = q_r[i-1];
      assign tag_in = tag_r[i-1];
    end

    always_comb begin
      trial   = {rem_in, nlo_in[QUO_W-1-i]};
      ge      = trial >= {1'b0, den_in};
      rem_nxt = ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
      q_nxt   = q_in;
      q_nxt[QUO_W-1-i] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i] <= 1'b0;
      else        v_r[i] <= v_in;
      rem_r[i] <= rem_nxt;
      nlo_r[i] <= nlo_in;
      den_r[i] <= den_in;
      q_r[i]   <= q_nxt;
      tag_r[i] <= tag_in;
    end
  end

  assign out_v   = v_r[QUO_W-1];
  assign quo     = q_r[QUO_W-1];
  assign out_tag = tag_r[QUO_W-1];

endmodule

// ===== design/dcso_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on dcso_pkg.
module dcso_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_v,
  input  logic [dcso_pkg::QUO_W-1:0]  val,
  input  dcso_pkg::lane_tag_t         in_tag,
  output logic                        out_v,
  output logic [dcso_pkg::ROOT_W-1:0] root,
  output logic [dcso_pkg::QUO_W-1:0]  out_val,
  output dcso_pkg::lane_tag_t         out_tag
);
  import dcso_pkg::*;

  logic              v_r    [ROOT_W];
  logic [SREM_W-1:0] rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [QUO_W-1:0]  val_r  [ROOT_W];
  lane_tag_t         tag_r  [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    logic              v_in;
    logic [SREM_W-1:0] rem_in, rem_nxt;
    logic [ROOT_W-1:0] root_in;
    logic [QUO_W-1:0]  val_in;
    lane_tag_t         tag_in;
    logic [SREM_W+1:0] rem_sh, trial;
    logic              ge;

    if (j == 0) begin : g_first
      assign v_in    = in_v;
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = val;
      assign tag_in  = in_tag;
    end else begin : g_next
      assign v_in    = v_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign val_in  = val_r[j-1];
      assign tag_in  = tag_r[j-1];
    end

    always_comb begin
      rem_sh  = {rem_in, val_in[QUO_W-1-2*j -: 2]};
      trial   = (SREM_W+2)'({root_in, 2'b01});
      ge      = rem_sh >= trial;
      rem_nxt = ge ? SREM_W'(rem_sh - trial) : rem_sh[SREM_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[j] <= 1'b0;
      else        v_r[j] <= v_in;
      rem_r[j]  <= rem_nxt;
      root_r[j] <= {root_in[ROOT_W-2:0], ge};
      val_r[j]  <= val_in;
      tag_r[j]  <= tag_in;
    end
  end

  assign out_v   = v_r[ROOT_W-1];
  assign root    = root_r[ROOT_W-1];
  assign out_val = val_r[ROOT_W-1];
  assign out_tag = tag_r[ROOT_W-1];

endmodule

// ===== design/direction_to_clamped_screen_offset.sv =====
// Top level: config registers, front stages, two divide/sqrt lanes, output register.
// Depends on dcso_pkg, dcso_front, dcso_div, dcso_sqrt.
//
// Usage:
//   Input: drive in_forward, in_right, in_up (signed Q1.14) with start high;
//   the word is taken at any edge where busy is low. busy is high only
//   during reset, so one word can enter every cycle.
//   Output: out_strobe is high for one cycle with out_valid_res, out_offset_x
//   and out_offset_y (signed, 1/16 pixel). Results leave in input order.
//   From accept to strobe a word passes 4 operand stages, a 34-stage
//   restoring divider (one quotient bit per stage), a 17-stage square root
//   (one root bit per stage) and the output register. Throughput is one word
//   per cycle, set by those fully pipelined units.
//   Config: cfg_index 0 writes focal_length, 1 writes max_radius; cfg_ready
//   is always high. Write only while no word is in flight.
//   Reset: clears both config registers and all stage valid bits; words in
//   flight are dropped. The receiver cannot stall, so the pipe never holds.
module direction_to_clamped_screen_offset (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [dcso_pkg::IN_W-1:0]    in_forward,
  input  logic signed [dcso_pkg::IN_W-1:0]    in_right,
  input  logic signed [dcso_pkg::IN_W-1:0]    in_up,
  output logic                                out_strobe,
  output logic                                out_valid_res,
  output logic signed [dcso_pkg::OUT_W-1:0]   out_offset_x,
  output logic signed [dcso_pkg::OUT_W-1:0]   out_offset_y,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dcso_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dcso_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import dcso_pkg::*;

  logic [FOCAL_W-1:0]  focal_r;
  logic [RADIUS_W-1:0] radius_r;

  assign cfg_ready = 1'b1;
  assign busy      = !rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r  <= '0;
      radius_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FOCAL)  focal_r  <= cfg_wdata[FOCAL_W-1:0];
      if (cfg_index == CFG_RADIUS) radius_r <= cfg_wdata[RADIUS_W-1:0];
    end
  end

  logic             f_v;
  logic [NUM_W-1:0] f_num_x, f_num_y;
  logic [DEN_W-1:0] f_den;
  lane_tag_t        f_tag_x, f_tag_y;

  dcso_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_v   (start && !busy),
    .fwd    (in_forward),
    .rgt    (in_right),
    .upc    (in_up),
    .focal  (focal_r),
    .radius (radius_r),
    .out_v  (f_v),
    .num_x  (f_num_x),
    .num_y  (f_num_y),
    .den    (f_den),
    .tag_x  (f_tag_x),
    .tag_y  (f_tag_y)
  );

  logic              d_v_x, d_v_y, s_v_x, s_v_y;
  logic [QUO_W-1:0]  d_q_x, d_q_y, s_val_x, s_val_y;
  lane_tag_t         d_tag_x, d_tag_y, s_tag_x, s_tag_y;
  logic [ROOT_W-1:0] s_root_x, s_root_y;

  dcso_div u_div_x (
    .clk (clk), .rst_n (rst_n), .in_v (f_v), .num (f_num_x), .den (f_den),
    .in_tag (f_tag_x), .out_v (d_v_x), .quo (d_q_x), .out_tag (d_tag_x)
  );

  dcso_div u_div_y (
    .clk (clk), .rst_n (rst_n), .in_v (f_v), .num (f_num_y), .den (f_den),
    .in_tag (f_tag_y), .out_v (d_v_y), .quo (d_q_y), .out_tag (d_tag_y)
  );

  dcso_sqrt u_sqrt_x (
    .clk (clk), .rst_n (rst_n), .in_v (d_v_x), .val (d_q_x), .in_tag (d_tag_x),
    .out_v (s_v_x), .root (s_root_x), .out_val (s_val_x), .out_tag (s_tag_x)
  );

  dcso_sqrt u_sqrt_y (
    .clk (clk), .rst_n (rst_n), .in_v (d_v_y), .val (d_q_y), .in_tag (d_tag_y),
    .out_v (s_v_y), .root (s_root_y), .out_val (s_val_y), .out_tag (s_tag_y)
  );

  // pinned: round(sqrt) = (isqrt(4x^2)+1)>>1, else the rounded quotient
  logic [OUT_W-1:0] mag_x, mag_y, ox_nxt, oy_nxt;

  always_comb begin
    mag_x  = s_tag_x.pin ? OUT_W'((ROOT_W+1)'(s_root_x) + 1'b1 >> 1) : s_val_x[OUT_W-1:0];
    mag_y  = s_tag_y.pin ? OUT_W'((ROOT_W+1)'(s_root_y) + 1'b1 >> 1) : s_val_y[OUT_W-1:0];
    ox_nxt = !s_tag_x.ok ? '0 : (s_tag_x.neg ? OUT_W'(-mag_x) : mag_x);
    oy_nxt = !s_tag_y.ok ? '0 : (s_tag_y.neg ? OUT_W'(-mag_y) : mag_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else        out_strobe <= s_v_x && s_v_y;
    out_valid_res <= s_tag_x.ok;
    out_offset_x  <= ox_nxt;
    out_offset_y  <= oy_nxt;
  end

endmodule

// ===== design/dcso_checker.sv =====
// Port-level checks for direction_to_clamped_screen_offset, with its bind.
// Depends on dcso_pkg.
module dcso_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_strobe,
  input logic                              out_valid_res,
  input logic signed [dcso_pkg::OUT_W-1:0] out_offset_x,
  input logic signed [dcso_pkg::OUT_W-1:0] out_offset_y
);
  import dcso_pkg::*;

  a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_strobe)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LATENCY))
    else $error("result without a matching input word");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_valid_res) |-> (out_offset_x == '0 && out_offset_y == '0))
    else $error("invalid result carries a nonzero offset");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_offset_x != 17'h10000 && out_offset_y != 17'h10000))
    else $error("offset outside its range");

endmodule

bind direction_to_clamped_screen_offset dcso_checker u_dcso_checker (.*);
